>>> rtl/bffa_pkg.sv
package bffa_pkg;

    localparam int NUM_W = 11;
    localparam int OP_W  = 2;
    localparam int CFG_INDEX_W = 2;

    // request codes
    localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_START    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_END      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_OFFSET = 2'd2;

    localparam logic [NUM_W-1:0] SCAN_START_RESET = 11'd1;
    localparam logic [NUM_W-1:0] SCAN_END_RESET   = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] number;
    } req_t;

    typedef struct packed {
        logic             in_use;
        logic             success;
        logic [NUM_W-1:0] allocated_number;
    } rsp_t;

    // outcome of checking one bitmap byte
    typedef struct packed {
        logic       found;
        logic [2:0] bit_pos;
        logic [7:0] set_data;
    } chk_t;

endpackage

>>> rtl/bffa_byte_check.sv
module bffa_byte_check #(
    parameter int ADDR_W = 7
) (
    input  logic [7:0]        byte_data,
    input  logic [ADDR_W-1:0] byte_addr,
    input  logic [ADDR_W+2:0] lo_idx,
    input  logic [ADDR_W+2:0] last_idx,
    output bffa_pkg::chk_t    chk
);

    logic [7:0] lo_mask;
    logic [7:0] hi_mask;
    logic [7:0] free_bits;

    always_comb begin
        // trim bits below the window start and above the window end
        lo_mask = (byte_addr == lo_idx[ADDR_W+2:3]) ? (8'hFF << lo_idx[2:0]) : 8'hFF;
        hi_mask = (byte_addr == last_idx[ADDR_W+2:3]) ?
                  (8'hFF >> (3'd7 - last_idx[2:0])) : 8'hFF;
        free_bits = ~byte_data & lo_mask & hi_mask;
    end

    always_comb begin
        chk.found   = 1'b0;
        chk.bit_pos = 3'd0;
        // lowest free bit wins
        for (int b = 7; b >= 0; b--) begin
            if (free_bits[b]) begin
                chk.found   = 1'b1;
                chk.bit_pos = 3'(b);
            end
        end
        chk.set_data = byte_data | (8'b1 << chk.bit_pos);
    end

endmodule

>>> rtl/bitmap_first_fit_allocator.sv
// First-fit bitmap allocator.
// Requests arrive on s_valid/s_ready/s_data (op, number); one result per
// request leaves on m_valid/m_ready/m_data (in_use, success, allocated_number).
// Registers scan_start, scan_end and number_offset are written on the
// cfg_valid/cfg_ready/cfg_index/cfg_data port, which is always ready.
// Test, set and clear are accepted with the byte read, then the
// read-modify-write step loads the result register. Allocate is accepted
// with the read of the first window byte, then scans one bitmap byte per
// cycle while the output register is free; an empty scan window fails
// without a read. The bitmap memory has one read and one write port.
// s_ready is high only while the sequencer is idle, so one request is in
// work at a time; a finished result sits in the output register while the
// next request is accepted.
// If the receiver stalls, a test, set or clear holds at its read-modify-write
// step and a scan pauses on its current byte until the output register frees
// up; no further request is accepted meanwhile.
// After reset a clearing pass zeroes the bitmap byte by byte;
// s_ready stays low meanwhile, configuration writes are taken as usual.
module bitmap_first_fit_allocator #(
    parameter int NUM_BITS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bffa_pkg::req_t                       s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bffa_pkg::rsp_t                       m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bffa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bffa_pkg::NUM_W-1:0]           cfg_data
);

    localparam int MAP_BYTES = (NUM_BITS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int IDX_W     = ADDR_W + 3;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [bffa_pkg::NUM_W-1:0] scan_start_reg;
    logic [bffa_pkg::NUM_W-1:0] scan_end_reg;
    logic                       offset_reg;

    logic [7:0] mem [MAP_BYTES];
    logic [7:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic [bffa_pkg::OP_W-1:0] op_reg, op_next;
    logic                      mapped_reg, mapped_next;
    logic [2:0]                bit_pos_reg, bit_pos_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          last_reg, last_next;
    logic                      empty_reg, empty_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;

    bffa_pkg::rsp_t out_reg, out_next;
    logic           m_valid_reg, m_valid_next;
    logic           out_load;
    logic           out_free;

    logic [31:0] num32, off32, idx32;
    logic [31:0] start32, end32, lo32, hi_raw32, hi32, last32;
    logic        mapped;
    logic        window_empty;

    bffa_pkg::chk_t chk;

    bffa_byte_check #(
        .ADDR_W (ADDR_W)
    ) u_check (
        .byte_data (rd_data_reg),
        .byte_addr (addr_reg),
        .lo_idx    (lo_reg),
        .last_idx  (last_reg),
        .chk       (chk)
    );

    // number to bit index, and the allocate window in bit indexes
    always_comb begin
        num32   = 32'(s_data.number);
        off32   = 32'(offset_reg);
        idx32   = num32 - off32;
        mapped  = (num32 >= off32) && (idx32 < 32'(NUM_BITS));
        start32 = 32'(scan_start_reg);
        end32   = 32'(scan_end_reg);
        lo32     = (start32 >= off32) ? (start32 - off32) : 32'd0;
        hi_raw32 = (end32 >= off32) ? (end32 - off32) : 32'd0;
        hi32     = (hi_raw32 > 32'(NUM_BITS)) ? 32'(NUM_BITS) : hi_raw32;
        window_empty = (lo32 >= hi32);
        last32  = hi32 - 32'd1;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        mapped_next   = mapped_reg;
        bit_pos_next  = bit_pos_reg;
        addr_next     = addr_reg;
        lo_next       = lo_reg;
        last_next     = last_reg;
        empty_next    = empty_reg;
        clr_addr_next = clr_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = rd_data_reg;
        out_load      = 1'b0;
        out_next      = out_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = 8'h00;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = s_data.op;
                    if (s_data.op == bffa_pkg::OP_ALLOC) begin
                        lo_next    = lo32[IDX_W-1:0];
                        last_next  = last32[IDX_W-1:0];
                        empty_next = window_empty;
                        addr_next  = lo32[IDX_W-1:3];
                        rd_en      = !window_empty;
                        rd_addr    = lo32[IDX_W-1:3];
                        state_next = ST_SCAN;
                    end else begin
                        mapped_next  = mapped;
                        bit_pos_next = idx32[2:0];
                        addr_next    = idx32[IDX_W-1:3];
                        rd_en        = mapped;
                        rd_addr      = idx32[IDX_W-1:3];
                        state_next   = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    out_next.in_use           = mapped_reg & rd_data_reg[bit_pos_reg];
                    out_next.success          = 1'b1;
                    out_next.allocated_number = '0;
                    wr_en   = mapped_reg && ((op_reg == bffa_pkg::OP_SET) ||
                                             (op_reg == bffa_pkg::OP_CLEAR));
                    wr_data = (op_reg == bffa_pkg::OP_SET) ?
                              (rd_data_reg | (8'b1 << bit_pos_reg)) :
                              (rd_data_reg & ~(8'b1 << bit_pos_reg));
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    out_next.in_use           = 1'b0;
                    out_next.success          = 1'b0;
                    out_next.allocated_number = '0;
                    if (empty_reg) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else if (chk.found) begin
                        out_load                  = 1'b1;
                        out_next.success          = 1'b1;
                        out_next.allocated_number = bffa_pkg::NUM_W'(
                            32'({addr_reg, chk.bit_pos}) + off32);
                        wr_en      = 1'b1;
                        wr_data    = chk.set_data;
                        state_next = ST_IDLE;
                    end else if (addr_reg == last_reg[IDX_W-1:3]) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        // fetch the next byte while this one is dropped
                        addr_next = addr_reg + 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = addr_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            scan_start_reg <= bffa_pkg::SCAN_START_RESET;
            scan_end_reg   <= bffa_pkg::SCAN_END_RESET;
            offset_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    bffa_pkg::CFG_SCAN_START:    scan_start_reg <= cfg_data;
                    bffa_pkg::CFG_SCAN_END:      scan_end_reg   <= cfg_data;
                    bffa_pkg::CFG_NUMBER_OFFSET: offset_reg     <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        mapped_reg  <= mapped_next;
        bit_pos_reg <= bit_pos_next;
        addr_reg    <= addr_next;
        lo_reg      <= lo_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg != ST_IDLE))
        else $error("bitmap written while sequencer idle");

    a_rmw_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.op != bffa_pkg::OP_ALLOC)) |=> (state_reg == ST_RMW))
        else $error("test/set/clear item did not enter read-modify-write");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.success || (m_data.allocated_number == '0)))
        else $error("failed allocate returned a number");

    a_in_use_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.in_use) |-> (m_data.success && (m_data.allocated_number == '0)))
        else $error("in_use set on an allocate result");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && !empty_reg) |-> (addr_reg <= last_reg[IDX_W-1:3]))
        else $error("scan ran past the window end");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BITS        = 1024;
    localparam int NO_ACCEPT_LIMIT = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 66;
    localparam int TAIL_CYCLES     = 150;
    localparam int PHASES          = 8;

    // index past the last register, writes to it must be ignored
    localparam logic [bffa_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    class alloc_checker;
        bit [MAP_BITS-1:0]          usage;
        logic [bffa_pkg::NUM_W-1:0] scan_start;
        logic [bffa_pkg::NUM_W-1:0] scan_end;
        bit                         number_offset;
        bffa_pkg::rsp_t             expected_q[$];
        int                         results_seen;
        int                         mismatches;

        function new();
            usage         = '0;
            scan_start    = bffa_pkg::SCAN_START_RESET;
            scan_end      = bffa_pkg::SCAN_END_RESET;
            number_offset = 1'b0;
            results_seen  = 0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [bffa_pkg::CFG_INDEX_W-1:0] idx,
                                logic [bffa_pkg::NUM_W-1:0] value);
            case (idx)
                bffa_pkg::CFG_SCAN_START:    scan_start = value;
                bffa_pkg::CFG_SCAN_END:      scan_end = value;
                bffa_pkg::CFG_NUMBER_OFFSET: number_offset = value[0];
                default: ;
            endcase
        endfunction

        // bit position of a number, -1 when it has no bit in the map
        function int bit_of(int number);
            int pos;
            pos = number - int'(number_offset);
            if (pos < 0 || pos >= MAP_BITS)
                return -1;
            return pos;
        endfunction

        function void take_request(bffa_pkg::req_t req);
            bffa_pkg::rsp_t rsp;
            int             pos;
            rsp = '0;
            rsp.success = 1'b1;
            if (req.op == bffa_pkg::OP_ALLOC) begin
                rsp.success = 1'b0;
                for (int n = scan_start; n < int'(scan_end); n++) begin
                    pos = bit_of(n);
                    if (pos >= 0 && !usage[pos]) begin
                        usage[pos] = 1'b1;
                        rsp.success = 1'b1;
                        rsp.allocated_number = bffa_pkg::NUM_W'(n);
                        break;
                    end
                end
            end else begin
                pos = bit_of(int'(req.number));
                if (pos >= 0) begin
                    rsp.in_use = usage[pos];
                    if (req.op == bffa_pkg::OP_SET)
                        usage[pos] = 1'b1;
                    else if (req.op == bffa_pkg::OP_CLEAR)
                        usage[pos] = 1'b0;
                end
            end
            expected_q.push_back(rsp);
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(bffa_pkg::rsp_t got);
            bffa_pkg::rsp_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d with nothing expected: in_use=%0d success=%0d num=%0d",
                                 results_seen, got.in_use, got.success, got.allocated_number));
                return;
            end
            want = expected_q.pop_front();
            if (got.in_use !== want.in_use || got.success !== want.success ||
                got.allocated_number !== want.allocated_number)
                report($sformatf("result %0d: got in_use=%0d success=%0d num=%0d, want %0d %0d %0d",
                                 results_seen, got.in_use, got.success, got.allocated_number,
                                 want.in_use, want.success, want.allocated_number));
        endtask
    endclass

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    bffa_pkg::req_t                       s_data;
    logic                                 m_valid;
    logic                                 m_ready;
    bffa_pkg::rsp_t                       m_data;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [bffa_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [bffa_pkg::NUM_W-1:0]           cfg_data;

    alloc_checker chk;
    bit           tx_idle_en;
    bit           rx_idle_en;
    int           holds_asked;
    int           quiet_cycles;

    bitmap_first_fit_allocator #(.NUM_BITS(MAP_BITS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                chk.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                chk.take_request(s_data);
            if (m_valid && m_ready)
                chk.check_response(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_idle_en || ($urandom_range(99) >= 36);
            end
        end
    end

    task automatic send_req(input logic [bffa_pkg::OP_W-1:0] op,
                            input logic [bffa_pkg::NUM_W-1:0] number);
        bffa_pkg::req_t req;
        req.op     = op;
        req.number = number;
        while (tx_idle_en && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // valid stays high across back-to-back writes, caller lowers it
    task automatic write_reg(input logic [bffa_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bffa_pkg::NUM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk.expected_q.size() != 0);
    endtask

    initial begin
        int                        lo_list[PHASES];
        int                        hi_list[PHASES];
        int                        ofs_list[PHASES];
        int                        edge_nums[6];
        int                        lo, hi, ofs, base, span, n, roll;
        logic [bffa_pkg::OP_W-1:0] op;

        lo_list      = '{0, 2047, 0, 1000, 1016, 100, 0, 1};
        hi_list      = '{2047, 0, 20, 1030, 1030, 100, 0, 1024};
        ofs_list     = '{1, 0, 0, 1, 0, 1, 0, 0};
        edge_nums    = '{0, 1, 1023, 1024, 1025, 2047};
        chk          = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = bffa_pkg::CFG_SCAN_START;
        cfg_data     = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        holds_asked  = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: bit updates, map edges, numbers past the map
        send_req(bffa_pkg::OP_TEST, 0);
        send_req(bffa_pkg::OP_SET, 0);
        send_req(bffa_pkg::OP_SET, 0);
        send_req(bffa_pkg::OP_TEST, 0);
        send_req(bffa_pkg::OP_CLEAR, 0);
        send_req(bffa_pkg::OP_CLEAR, 0);
        send_req(bffa_pkg::OP_SET, 1023);
        send_req(bffa_pkg::OP_TEST, 1023);
        send_req(bffa_pkg::OP_SET, 1024);
        send_req(bffa_pkg::OP_TEST, 1024);
        send_req(bffa_pkg::OP_CLEAR, 2047);
        send_req(bffa_pkg::OP_ALLOC, 2047);
        send_req(bffa_pkg::OP_ALLOC, 0);
        send_req(bffa_pkg::OP_CLEAR, 1);
        send_req(bffa_pkg::OP_ALLOC, 0);
        send_req(bffa_pkg::OP_TEST, 2);
        drain();

        // offset 1 with a tiny window: unmapped number 0 skipped, then a failed scan
        write_reg(bffa_pkg::CFG_NUMBER_OFFSET, 11'h7ff);
        write_reg(bffa_pkg::CFG_SCAN_START, 0);
        write_reg(bffa_pkg::CFG_SCAN_END, 3);
        cfg_valid <= 1'b0;
        send_req(bffa_pkg::OP_TEST, 0);
        send_req(bffa_pkg::OP_SET, 1024);
        send_req(bffa_pkg::OP_TEST, 1);
        send_req(bffa_pkg::OP_ALLOC, 0);
        send_req(bffa_pkg::OP_ALLOC, 0);
        send_req(bffa_pkg::OP_CLEAR, 1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            lo  = lo_list[p];
            hi  = hi_list[p];
            ofs = ofs_list[p];
            if (p == 6) begin
                lo  = $urandom_range(1024);
                hi  = lo + $urandom_range(48, 1);
                ofs = $urandom_range(1);
            end
            write_reg(bffa_pkg::CFG_SCAN_START, bffa_pkg::NUM_W'(lo));
            write_reg(bffa_pkg::CFG_SCAN_END, bffa_pkg::NUM_W'(hi));
            // upper bits are junk, only bit 0 counts
            write_reg(bffa_pkg::CFG_NUMBER_OFFSET, {10'($urandom_range(1023)), ofs[0]});
            if (p == 1)
                write_reg(CFG_UNUSED, 11'h7ff);
            cfg_valid <= 1'b0;

            tx_idle_en = (p != PHASES - 1);
            rx_idle_en <= (p != PHASES - 1);
            if (p == 2)
                holds_asked <= holds_asked + 1;

            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 30)
                    op = bffa_pkg::OP_ALLOC;
                else if (roll < 55)
                    op = bffa_pkg::OP_SET;
                else if (roll < 80)
                    op = bffa_pkg::OP_CLEAR;
                else
                    op = bffa_pkg::OP_TEST;
                roll = $urandom_range(99);
                if (roll < 70) begin
                    // mostly around the scan window so allocs and clears interact
                    base = (lo < hi) ? lo : hi;
                    span = (lo < hi) ? hi - lo : 16;
                    n = base + $urandom_range(span + 3) - 2;
                    if (n < 0)
                        n = 0;
                    if (n > 2047)
                        n = 2047;
                end else if (roll < 85) begin
                    n = $urandom_range(2047);
                end else begin
                    n = edge_nums[$urandom_range(5)];
                end
                send_req(op, bffa_pkg::NUM_W'(n));
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (chk.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
